FILE: hw/rtl/ahfp_pkg.sv
// Shared types, codes and constants for the audio header field parser.
// Used by the parser core, the result queue, the top level and the checker.
// Has no dependencies of its own.
package ahfp_pkg;

	// Default values for top-level parameters.
	localparam int OFFSET_BITS_DEF  = 16;
	localparam int MAX_CHAPTERS_DEF = 255;

	// Configuration register.
	localparam int               HDR_LEN_W     = 16;
	localparam logic [15:0]      HDR_LEN_RESET = 16'd4096;

	// Result queue depth; an input transaction may push two results.
	localparam int QUEUE_DEPTH = 4;

	// Fixed field lengths of the header.
	localparam logic [31:0] HASH_LENGTH = 32'd20;
	localparam logic [4:0]  HASH_LAST   = 5'd19;
	localparam logic [1:0]  MAGIC_LAST  = 2'd3;

	// Field numbers carried in a tag.
	localparam logic [7:0] FIELD_HASH     = 8'd1;
	localparam logic [7:0] FIELD_LENGTH   = 8'd2;
	localparam logic [7:0] FIELD_ID       = 8'd3;
	localparam logic [7:0] FIELD_CHAPTERS = 8'd4;
	localparam logic [7:0] FIELD_FILL     = 8'd5;

	// Wire types carried in a tag.
	localparam logic [2:0] WIRE_VARINT = 3'd0;
	localparam logic [2:0] WIRE_LEN    = 3'd2;

	// Record kinds.
	localparam logic [2:0] KIND_HASH     = 3'd0;
	localparam logic [2:0] KIND_LENGTH   = 3'd1;
	localparam logic [2:0] KIND_ID       = 3'd2;
	localparam logic [2:0] KIND_CHAPTER  = 3'd3;
	localparam logic [2:0] KIND_FINISHED = 3'd4;

	// Parse status codes.
	localparam logic [2:0] STATUS_OK             = 3'd0;
	localparam logic [2:0] STATUS_BAD_MAGIC      = 3'd1;
	localparam logic [2:0] STATUS_BAD_HASH_LEN   = 3'd2;
	localparam logic [2:0] STATUS_BAD_HEADER_LEN = 3'd3;
	localparam logic [2:0] STATUS_UNEXPECTED     = 3'd4;
	localparam logic [2:0] STATUS_TRUNCATED      = 3'd5;

	// One input transaction.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [2:0]  record_kind;
		logic [31:0] record_value;
		logic [7:0]  record_index;
		logic [2:0]  parse_status;
		logic        last_record;
	} result_t;

	// Results produced by one accepted input, handed to the queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Expected magic byte at each position.
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] val;
		case (pos)
			2'd0: val = 8'h00;
			2'd1: val = 8'h00;
			2'd2: val = 8'h0F;
			2'd3: val = 8'hFC;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

FILE: hw/rtl/ahfp_core.sv
// Parser state and per-byte decode logic for the audio header field parser.
// Depends on ahfp_pkg; produces up to two results per accepted byte.
module ahfp_core #(
	parameter int OFFSET_BITS  = ahfp_pkg::OFFSET_BITS_DEF,
	parameter int MAX_CHAPTERS = ahfp_pkg::MAX_CHAPTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  ahfp_pkg::item_t                  item,
	input  logic                             cfg_we,
	input  logic [ahfp_pkg::HDR_LEN_W-1:0]   cfg_wdata,
	output ahfp_pkg::push_t                  push
);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_TAG,
		PH_VARINT,
		PH_HASH,
		PH_CHAP,
		PH_DONE
	} phase_t;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	// State registers.
	phase_t                         phase_q, phase_d;
	logic [1:0]                     magic_q, magic_d;
	logic [7:0]                     field_q, field_d;
	logic [31:0]                    acc_q, acc_d;
	logic                           hi_q, hi_d;
	logic [3:0]                     cnt_q, cnt_d;
	logic [OFFSET_BITS-1:0]         off_q, off_d;
	logic [4:0]                     hash_q, hash_d;
	logic [OFFSET_BITS-1:0]         end_q, end_d;
	logic [7:0]                     total_q, total_d;
	logic [ahfp_pkg::HDR_LEN_W-1:0] hdr_len_q;

	// Decode helpers.
	logic [7:0]             b;
	logic [4:0]             tag_field;
	logic [2:0]             tag_wire;
	logic                   tag_legal;
	logic [6:0]             shamt;
	logic [63:0]            wide;
	logic [31:0]            take_lo;
	logic                   take_hi;
	logic                   take_done;
	logic [3:0]             cnt_inc;
	logic [OFFSET_BITS-1:0] off_new;
	logic [OFFSET_BITS-1:0] room;
	logic                   block_big;
	logic [OFFSET_BITS-1:0] end_c;
	logic                   hash_len_ok;
	logic                   fill_ok;
	logic                   case_v;
	ahfp_pkg::result_t      case_r;
	logic                   fin_v;
	ahfp_pkg::result_t      fin_r;

	function automatic ahfp_pkg::result_t make_result(
		input logic [2:0]  kind,
		input logic [31:0] value,
		input logic [7:0]  index,
		input logic [2:0]  status
	);
		ahfp_pkg::result_t r;
		r.record_kind  = kind;
		r.record_value = value;
		r.record_index = index;
		r.parse_status = status;
		r.last_record  = 1'b0;
		return r;
	endfunction

	// Varint byte accumulation: low 32 bits kept, upper 32 bits folded into a flag.
	always_comb begin
		b         = item.data_byte;
		tag_field = b[7:3];
		tag_wire  = b[2:0];
		shamt     = 7'(cnt_q) * 7'd7;
		wide      = {57'd0, b[6:0]} << shamt;
		if (cnt_q < 4'd10) begin
			take_lo = acc_q | wide[31:0];
			take_hi = hi_q | (|wide[63:32]);
		end else begin
			take_lo = acc_q;
			take_hi = hi_q;
		end
		take_done = ~b[7];
		cnt_inc   = (cnt_q == 4'hF) ? cnt_q : cnt_q + 4'd1;
	end

	// Offset, chapter block end, length and tag checks.
	always_comb begin
		off_new = off_q;
		if (phase_q != PH_DONE && off_q != OFF_MAX) begin
			off_new = off_q + OFFSET_BITS'(1);
		end
		room        = OFF_MAX - off_new;
		block_big   = take_hi || (take_lo >= 32'(room));
		end_c       = block_big ? OFF_MAX : off_new + OFFSET_BITS'(take_lo);
		hash_len_ok = !take_hi && (take_lo == ahfp_pkg::HASH_LENGTH);
		fill_ok     = !take_hi && (take_lo <= 32'(hdr_len_q)) &&
			((32'(hdr_len_q) - take_lo) == 32'(off_new));
		tag_legal = (((8'(tag_field) == ahfp_pkg::FIELD_HASH) ||
			(8'(tag_field) == ahfp_pkg::FIELD_CHAPTERS) ||
			(8'(tag_field) == ahfp_pkg::FIELD_FILL)) && tag_wire == ahfp_pkg::WIRE_LEN) ||
			(((8'(tag_field) == ahfp_pkg::FIELD_LENGTH) ||
			(8'(tag_field) == ahfp_pkg::FIELD_ID)) && tag_wire == ahfp_pkg::WIRE_VARINT);
	end

	// Next state and results for the byte on the input.
	always_comb begin
		phase_d = phase_q;
		magic_d = magic_q;
		field_d = field_q;
		acc_d   = acc_q;
		hi_d    = hi_q;
		cnt_d   = cnt_q;
		off_d   = off_new;
		hash_d  = hash_q;
		end_d   = end_q;
		total_d = total_q;
		case_v  = 1'b0;
		case_r  = '0;

		case (phase_q)
			PH_MAGIC: begin
				if (b != ahfp_pkg::magic_byte(magic_q)) begin
					case_v  = 1'b1;
					case_r  = make_result(ahfp_pkg::KIND_FINISHED, 32'd0, total_q,
						ahfp_pkg::STATUS_BAD_MAGIC);
					phase_d = PH_DONE;
				end else if (magic_q == ahfp_pkg::MAGIC_LAST) begin
					magic_d = 2'd0;
					phase_d = PH_TAG;
				end else begin
					magic_d = magic_q + 2'd1;
				end
			end
			PH_TAG: begin
				field_d = 8'(tag_field);
				if (tag_legal) begin
					acc_d   = '0;
					hi_d    = 1'b0;
					cnt_d   = '0;
					phase_d = PH_VARINT;
				end else begin
					case_v  = 1'b1;
					case_r  = make_result(ahfp_pkg::KIND_FINISHED, 32'd0, total_q,
						ahfp_pkg::STATUS_UNEXPECTED);
					phase_d = PH_DONE;
				end
			end
			PH_VARINT: begin
				if (!take_done) begin
					acc_d = take_lo;
					hi_d  = take_hi;
					cnt_d = cnt_inc;
				end else begin
					acc_d = '0;
					hi_d  = 1'b0;
					cnt_d = '0;
					case (field_q)
						ahfp_pkg::FIELD_HASH: begin
							if (hash_len_ok) begin
								hash_d  = '0;
								phase_d = PH_HASH;
							end else begin
								case_v  = 1'b1;
								case_r  = make_result(ahfp_pkg::KIND_FINISHED, 32'd0,
									total_q, ahfp_pkg::STATUS_BAD_HASH_LEN);
								phase_d = PH_DONE;
							end
						end
						ahfp_pkg::FIELD_LENGTH: begin
							case_v  = 1'b1;
							case_r  = make_result(ahfp_pkg::KIND_LENGTH, take_lo, 8'd0,
								ahfp_pkg::STATUS_OK);
							phase_d = PH_TAG;
						end
						ahfp_pkg::FIELD_ID: begin
							case_v  = 1'b1;
							case_r  = make_result(ahfp_pkg::KIND_ID, take_lo, 8'd0,
								ahfp_pkg::STATUS_OK);
							phase_d = PH_TAG;
						end
						ahfp_pkg::FIELD_CHAPTERS: begin
							total_d = '0;
							end_d   = end_c;
							phase_d = (end_c > off_new) ? PH_CHAP : PH_TAG;
						end
						default: begin
							// Fill count closes the header.
							case_v  = 1'b1;
							case_r  = make_result(ahfp_pkg::KIND_FINISHED, 32'd0, total_q,
								fill_ok ? ahfp_pkg::STATUS_OK :
								ahfp_pkg::STATUS_BAD_HEADER_LEN);
							phase_d = PH_DONE;
						end
					endcase
				end
			end
			PH_HASH: begin
				case_v = 1'b1;
				case_r = make_result(ahfp_pkg::KIND_HASH, {24'd0, b}, {3'd0, hash_q},
					ahfp_pkg::STATUS_OK);
				if (hash_q == ahfp_pkg::HASH_LAST) begin
					hash_d  = '0;
					phase_d = PH_TAG;
				end else begin
					hash_d = hash_q + 5'd1;
				end
			end
			PH_CHAP: begin
				if (!take_done) begin
					acc_d = take_lo;
					hi_d  = take_hi;
					cnt_d = cnt_inc;
				end else begin
					acc_d = '0;
					hi_d  = 1'b0;
					cnt_d = '0;
					// Chapters past the limit are consumed but not reported.
					if (total_q < 8'(MAX_CHAPTERS)) begin
						case_v  = 1'b1;
						case_r  = make_result(ahfp_pkg::KIND_CHAPTER, take_lo, total_q,
							ahfp_pkg::STATUS_OK);
						total_d = total_q + 8'd1;
					end
					if (off_new >= end_q) begin
						phase_d = PH_TAG;
					end
				end
			end
			default: begin
			end
		endcase

		// End of data closes an open parse and rearms the magic check.
		fin_v = item.last_byte && (phase_d != PH_DONE);
		fin_r = make_result(ahfp_pkg::KIND_FINISHED, 32'd0, total_d,
			(phase_d == PH_TAG) ? ahfp_pkg::STATUS_OK : ahfp_pkg::STATUS_TRUNCATED);
		if (item.last_byte) begin
			phase_d = PH_MAGIC;
			magic_d = '0;
			field_d = '0;
			acc_d   = '0;
			hi_d    = 1'b0;
			cnt_d   = '0;
			off_d   = '0;
			hash_d  = '0;
			end_d   = '0;
			total_d = '0;
		end

		// Pack the results of this byte for the queue.
		push = '0;
		if (case_v && fin_v) begin
			push.count              = 2'd2;
			push.first              = case_r;
			push.second             = fin_r;
			push.second.last_record = 1'b1;
		end else if (case_v) begin
			push.count             = 2'd1;
			push.first             = case_r;
			push.first.last_record = 1'b1;
		end else if (fin_v) begin
			push.count             = 2'd1;
			push.first             = fin_r;
			push.first.last_record = 1'b1;
		end
		if (!accept) begin
			push.count = 2'd0;
		end
	end

	// Parser state advances on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			magic_q <= '0;
			field_q <= '0;
			acc_q   <= '0;
			hi_q    <= 1'b0;
			cnt_q   <= '0;
			off_q   <= '0;
			hash_q  <= '0;
			end_q   <= '0;
			total_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			magic_q <= magic_d;
			field_q <= field_d;
			acc_q   <= acc_d;
			hi_q    <= hi_d;
			cnt_q   <= cnt_d;
			off_q   <= off_d;
			hash_q  <= hash_d;
			end_q   <= end_d;
			total_q <= total_d;
		end
	end

	// Expected header length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_len_q <= ahfp_pkg::HDR_LEN_RESET;
		end else if (cfg_we) begin
			hdr_len_q <= cfg_wdata;
		end
	end

endmodule

FILE: hw/rtl/ahfp_result_queue.sv
// Small result queue that takes up to two results per cycle and drains one when the output is ready.
// Depends on ahfp_pkg for the result and push types.
module ahfp_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ahfp_pkg::push_t   push,
	output logic              has_room,
	output logic              result_valid,
	input  logic              result_ready,
	output ahfp_pkg::result_t result
);

	localparam int DEPTH = ahfp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ahfp_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	// Room for a transaction that brings two results.
	assign has_room     = count_q <= CNT_W'(DEPTH - 2);
	assign result_valid = count_q != '0;
	assign result       = mem_q[rd_q];
	assign pop          = result_valid && result_ready;

	// Storage writes, one or two entries.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

FILE: hw/rtl/audio_header_field_parser.sv
// A result is written into the result queue when its byte is accepted and is offered
// from there behind any earlier results. One header byte is taken per cycle while the
// four-entry result queue has two free slots; a byte may yield two results, offered in turn.
// Reset clears all parse state to the magic check and loads header_length with 4096.
// Top level; depends on ahfp_pkg, ahfp_core and ahfp_result_queue.
module audio_header_field_parser #(
	parameter int OFFSET_BITS  = ahfp_pkg::OFFSET_BITS_DEF,
	parameter int MAX_CHAPTERS = ahfp_pkg::MAX_CHAPTERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  ahfp_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output ahfp_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [ahfp_pkg::HDR_LEN_W-1:0] cfg_wdata
);

	ahfp_pkg::push_t push;
	logic            accept;

	// An input transaction completes when valid meets ready.
	assign accept = item_valid && item_ready;

	ahfp_core #(
		.OFFSET_BITS  (OFFSET_BITS),
		.MAX_CHAPTERS (MAX_CHAPTERS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push)
	);

	ahfp_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.has_room     (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: hw/rtl/ahfp_checker.sv
// Port-level checks for the audio header field parser, bound to the top level.
// Depends on ahfp_pkg and audio_header_field_parser.
module ahfp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input ahfp_pkg::result_t result
);

	// A stalled result transaction stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	// Only a finished record carries a nonzero status.
	a_status_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind != ahfp_pkg::KIND_FINISHED |->
		result.parse_status == ahfp_pkg::STATUS_OK)
		else $error("status set on a data record");

	// A finished record closes its byte and carries a zero value.
	a_finish_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind == ahfp_pkg::KIND_FINISHED |->
		result.last_record && result.record_value == 32'd0)
		else $error("malformed finished record");

	// Hash bytes carry an index below the hash length and a byte-wide value.
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind == ahfp_pkg::KIND_HASH |->
		result.record_index < 8'd20 && result.record_value[31:8] == 24'd0)
		else $error("hash record out of range");

endmodule

bind audio_header_field_parser ahfp_checker u_ahfp_checker (.*);
